### hdl/ssc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types, constants and table functions for the selective scan step.
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int FEATURES_DEF       = 16;
    localparam int STATES_DEF         = 16;
    localparam int EXP_TABLE_SIZE_DEF = 256;
    localparam int ADDR_W             = 14;
    localparam int QUEUE_DEPTH        = 2;
    localparam int CFG_W              = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    localparam logic [1:0] MODE_SCAN = 2'd0;
    localparam logic [1:0] MODE_LOAD = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic REG_FEATURES = 1'b0;
    localparam logic REG_STATES   = 1'b1;

    localparam logic [63:0] LN2_Q30   = 64'd744261118;
    localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;

    typedef enum logic [1:0] {
        OP_SCAN,
        OP_LOAD,
        OP_READ,
        OP_NONE
    } op_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  feature_index;
        logic [3:0]  state_index;
        logic [15:0] x_value;
        logic [15:0] dt_value;
        logic [15:0] a_coef;
        logic [15:0] b_coef;
        logic [15:0] c_coef;
        logic [31:0] init_value;
        logic        end_of_sequence;
    } request_t;

    typedef struct packed {
        logic [31:0] y_value;
        logic [31:0] state_value;
        logic        saturated;
        logic        index_error;
        logic        last_out;
    } result_t;

    typedef struct packed {
        op_t         op;
        logic        ierr;
        logic [31:0] init;
        logic [15:0] c;
        logic        last;
    } carry_t;

    typedef struct packed {
        carry_t            info;
        logic [ADDR_W-1:0] addr;
        logic [32:0]       abar;
        logic [48:0]       bdx;
    } work_t;

    function automatic logic [63:0] div_small(logic [63:0] v, int k);
        logic [63:0] r;
        unique case (k)
            2:  r = v / 64'd2;
            3:  r = v / 64'd3;
            4:  r = v / 64'd4;
            5:  r = v / 64'd5;
            6:  r = v / 64'd6;
            7:  r = v / 64'd7;
            8:  r = v / 64'd8;
            9:  r = v / 64'd9;
            10: r = v / 64'd10;
            11: r = v / 64'd11;
            12: r = v / 64'd12;
            13: r = v / 64'd13;
            14: r = v / 64'd14;
            15: r = v / 64'd15;
            16: r = v / 64'd16;
            17: r = v / 64'd17;
            18: r = v / 64'd18;
            19: r = v / 64'd19;
            20: r = v / 64'd20;
            default: r = v;
        endcase
        return r;
    endfunction

    // 2^(i/2^lg) in Q1.15 from a taylor series of exp(i*ln2/2^lg)
    function automatic logic [15:0] exp_entry(int i, int lg);
        logic [63:0] u;
        logic [63:0] sum;
        logic [63:0] term;
        u    = (64'(i) * LN2_Q30) >> lg;
        sum  = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int k = 1; k <= 20; k++)
        begin
            term = div_small((term * u) >> 30, k);
            sum  = sum + term;
        end
        return 16'((sum + (64'd1 << 14)) >> 15);
    endfunction

endpackage

### hdl/selective_scan_1d_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_scan_1d_step
// Fixed-point selective state-space scan, one state element per beat.
// ----------------------------------------------------------------------------
// throughput: one beat per cycle while the result queue has room; a beat reading an entry
//   that one of the two items ahead of it in the state update stages still writes waits for
//   the single write port of the state memory
// reset: both sizes in use return to 16; the state memory is zeroed by a pass over
//   all FEATURES*STATES entries (256 by default) before the first item runs
module selective_scan_1d_step #(
    parameter int FEATURES       = ssc_pkg::FEATURES_DEF,
    parameter int STATES         = ssc_pkg::STATES_DEF,
    parameter int EXP_TABLE_SIZE = ssc_pkg::EXP_TABLE_SIZE_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  ssc_pkg::request_t         request,
    output logic                      empty,
    input  logic                      pop,
    output ssc_pkg::result_t          result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [ssc_pkg::CFG_W-1:0] cfg_data
);
    logic [ssc_pkg::CFG_W-1:0] features_reg, states_reg;

    logic             q_push, q_full, q_pop, q_empty;
    ssc_pkg::work_t   q_wdata, q_rdata;
    logic             out_push, out_full;
    ssc_pkg::result_t out_wdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            features_reg <= ssc_pkg::CFG_RESET;
            states_reg   <= ssc_pkg::CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ssc_pkg::REG_FEATURES: features_reg <= cfg_data;
                ssc_pkg::REG_STATES:   states_reg   <= cfg_data;
            endcase
        end
    end

    ssc_front #(
        .FEATURES       (FEATURES),
        .STATES         (STATES),
        .EXP_TABLE_SIZE (EXP_TABLE_SIZE)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .request         (request),
        .features_in_use (features_reg),
        .states_in_use   (states_reg),
        .q_push          (q_push),
        .q_full          (q_full),
        .q_data          (q_wdata)
    );

    ssc_queue #(
        .T     (ssc_pkg::work_t),
        .DEPTH (ssc_pkg::QUEUE_DEPTH)
    ) u_work_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .full  (q_full),
        .wdata (q_wdata),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    ssc_back #(
        .FEATURES (FEATURES),
        .STATES   (STATES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_rdata),
        .q_pop    (q_pop),
        .out_push (out_push),
        .out_full (out_full),
        .out_data (out_wdata)
    );

    ssc_queue #(
        .T     (ssc_pkg::result_t),
        .DEPTH (ssc_pkg::QUEUE_DEPTH)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .full  (out_full),
        .wdata (out_wdata),
        .pop   (pop),
        .empty (empty),
        .rdata (result)
    );

`ifndef SYNTHESIS
    a_work_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && q_full |-> full)
        else $error("work queue pushed while full without stalling the input");

    a_work_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("back end took an item from an empty work queue");

    a_result_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_full && !pop |=> !out_push || !$stable(out_wdata) || out_full)
        else $error("result beat lost at the result queue");
`endif

endmodule

### hdl/ssc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_queue
// Small first-in first-out buffer with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module ssc_queue #(
    parameter type T     = logic,
    parameter int  DEPTH = ssc_pkg::QUEUE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  T     wdata,
    input  logic pop,
    output logic empty,
    output T     rdata
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                slot_reg [DEPTH];
    logic [PW-1:0]   head_reg, head_next;
    logic [PW-1:0]   tail_reg, tail_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_push)
        begin
            tail_next = (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (do_pop)
        begin
            head_next = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[tail_reg] <= wdata;
        end
    end

endmodule

### hdl/ssc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_front
// Accepts items, checks indices, forms the address and computes the decay
// factor exp(a*dt) and the input term b*dt*x ahead of the state access.
// ----------------------------------------------------------------------------
module ssc_front #(
    parameter int FEATURES       = ssc_pkg::FEATURES_DEF,
    parameter int STATES         = ssc_pkg::STATES_DEF,
    parameter int EXP_TABLE_SIZE = ssc_pkg::EXP_TABLE_SIZE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  ssc_pkg::request_t           request,
    input  logic [ssc_pkg::CFG_W-1:0]   features_in_use,
    input  logic [ssc_pkg::CFG_W-1:0]   states_in_use,
    output logic                        q_push,
    input  logic                        q_full,
    output ssc_pkg::work_t              q_data
);
    localparam int L = $clog2(EXP_TABLE_SIZE);

    logic [15:0] rom [EXP_TABLE_SIZE];

    for (genvar g = 0; g < EXP_TABLE_SIZE; g++)
    begin : g_rom
        assign rom[g] = ssc_pkg::exp_entry(g, L);
    end

    logic adv;

    // input stage
    logic              f0_valid_reg;
    ssc_pkg::request_t f0_reg;

    // stage 1
    logic                       f1_valid_reg;
    ssc_pkg::carry_t            f1_info_reg, f1_info_next;
    logic [ssc_pkg::ADDR_W-1:0] f1_addr_reg, f1_addr_next;
    logic signed [32:0]         f1_z_reg, f1_z_next;
    logic signed [32:0]         f1_bd_reg, f1_bd_next;
    logic [15:0]                f1_x_reg;

    // stage 2
    logic                       f2_valid_reg;
    ssc_pkg::carry_t            f2_info_reg;
    logic [ssc_pkg::ADDR_W-1:0] f2_addr_reg;
    logic signed [57:0]         f2_zl_reg, f2_zl_next;
    logic signed [48:0]         f2_bdx_reg, f2_bdx_next;
    logic signed [25:0]         zc;

    // stage 3
    logic                       f3_valid_reg;
    ssc_pkg::carry_t            f3_info_reg;
    logic [ssc_pkg::ADDR_W-1:0] f3_addr_reg;
    logic [48:0]                f3_bdx_reg;
    logic [4:0]                 f3_n_reg, f3_n_next;
    logic [15:0]                f3_w_reg, f3_w_next;
    logic [15:0]                f3_lo_reg, f3_lo_next;
    logic [16:0]                f3_hi_reg, f3_hi_next;
    logic [57:0]                v_full;
    logic [49:0]                frac;
    logic [L-1:0]               idx;

    // stage 4
    logic                       f4_valid_reg;
    ssc_pkg::carry_t            f4_info_reg;
    logic [ssc_pkg::ADDR_W-1:0] f4_addr_reg;
    logic [48:0]                f4_bdx_reg;
    logic [4:0]                 f4_n_reg;
    logic [32:0]                f4_mant_reg, f4_mant_next;

    int unsigned flim, slim;
    logic        in_range;

    assign adv  = !(f4_valid_reg && q_full);
    assign full = !adv;

    // stage 1: classify, address, first products
    always_comb
    begin
        flim = (32'(features_in_use) > 32'(FEATURES)) ? 32'(FEATURES)
                                                       : 32'(features_in_use);
        slim = (32'(states_in_use) > 32'(STATES)) ? 32'(STATES) : 32'(states_in_use);
        in_range = (32'(f0_reg.feature_index) < flim) && (32'(f0_reg.state_index) < slim);
        f1_info_next.ierr = 1'b0;
        f1_info_next.init = f0_reg.init_value;
        f1_info_next.c    = f0_reg.c_coef;
        f1_info_next.last = f0_reg.end_of_sequence;
        unique case (f0_reg.mode)
            ssc_pkg::MODE_SCAN: f1_info_next.op = ssc_pkg::OP_SCAN;
            ssc_pkg::MODE_LOAD: f1_info_next.op = ssc_pkg::OP_LOAD;
            ssc_pkg::MODE_READ: f1_info_next.op = ssc_pkg::OP_READ;
            ssc_pkg::MODE_NONE: f1_info_next.op = ssc_pkg::OP_NONE;
        endcase
        if (f0_reg.mode != ssc_pkg::MODE_NONE && !in_range)
        begin
            f1_info_next.op   = ssc_pkg::OP_NONE;
            f1_info_next.ierr = 1'b1;
        end
        f1_addr_next = ssc_pkg::ADDR_W'(32'(f0_reg.feature_index) * 32'(STATES)
                                        + 32'(f0_reg.state_index));
        f1_z_next  = $signed(f0_reg.a_coef) * $signed({1'b0, f0_reg.dt_value});
        f1_bd_next = $signed(f0_reg.b_coef) * $signed({1'b0, f0_reg.dt_value});
    end

    // stage 2: clamp the exponent argument, scale by log2(e)
    always_comb
    begin
        if (f1_z_reg < -33'sd16777216)
        begin
            zc = -26'sd16777216;
        end
        else if (f1_z_reg > 33'sd4194304)
        begin
            zc = 26'sd4194304;
        end
        else
        begin
            zc = f1_z_reg[25:0];
        end
        f2_zl_next  = zc * $signed({1'b0, ssc_pkg::LOG2E_Q30});
        f2_bdx_next = f1_bd_reg * $signed(f1_x_reg);
    end

    // stage 3: split into exponent, table index and weight
    always_comb
    begin
        v_full     = 58'(f2_zl_reg + (58'sd24 <<< 50));
        frac       = v_full[49:0];
        idx        = frac[49 -: L];
        f3_n_next  = v_full[54:50];
        f3_w_next  = frac[49-L -: 16];
        f3_lo_next = rom[idx];
        f3_hi_next = (idx == L'(EXP_TABLE_SIZE - 1)) ? 17'h10000
                                                     : {1'b0, rom[idx + 1'b1]};
    end

    // stage 4: interpolate
    assign f4_mant_next = {1'b0, f3_lo_reg, 16'h0000}
                        + 33'((f3_hi_reg - {1'b0, f3_lo_reg}) * f3_w_reg);

    assign q_push        = f4_valid_reg;
    assign q_data.info   = f4_info_reg;
    assign q_data.addr   = f4_addr_reg;
    assign q_data.bdx    = f4_bdx_reg;
    assign q_data.abar   = 33'((64'(f4_mant_reg) << f4_n_reg) >> 29);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
            f4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f0_valid_reg <= push;
            f1_valid_reg <= f0_valid_reg;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
            f4_valid_reg <= f3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f0_reg      <= request;
            f1_info_reg <= f1_info_next;
            f1_addr_reg <= f1_addr_next;
            f1_z_reg    <= f1_z_next;
            f1_bd_reg   <= f1_bd_next;
            f1_x_reg    <= f0_reg.x_value;
            f2_info_reg <= f1_info_reg;
            f2_addr_reg <= f1_addr_reg;
            f2_zl_reg   <= f2_zl_next;
            f2_bdx_reg  <= f2_bdx_next;
            f3_info_reg <= f2_info_reg;
            f3_addr_reg <= f2_addr_reg;
            f3_bdx_reg  <= f2_bdx_reg;
            f3_n_reg    <= f3_n_next;
            f3_w_reg    <= f3_w_next;
            f3_lo_reg   <= f3_lo_next;
            f3_hi_reg   <= f3_hi_next;
            f4_info_reg <= f3_info_reg;
            f4_addr_reg <= f3_addr_reg;
            f4_bdx_reg  <= f3_bdx_reg;
            f4_n_reg    <= f3_n_reg;
            f4_mant_reg <= f4_mant_next;
        end
    end

endmodule

### hdl/ssc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_back
// Reads the state entry, applies the update, writes it back and forms the
// output product. Holds an item whose entry is still being updated, and
// clears the state memory one entry per cycle after reset.
// ----------------------------------------------------------------------------
module ssc_back #(
    parameter int FEATURES = ssc_pkg::FEATURES_DEF,
    parameter int STATES   = ssc_pkg::STATES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  ssc_pkg::work_t    q_head,
    output logic              q_pop,
    output logic              out_push,
    input  logic              out_full,
    output ssc_pkg::result_t  out_data
);
    localparam int DEPTH = FEATURES * STATES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0]      mem [DEPTH];
    logic [31:0]      rd_reg;
    logic             clr_busy_reg;
    logic [AW-1:0]    clr_addr_reg;

    logic adv, issue, hazard, head_reads, b1_writes, b2_writes, mem_we;

    logic               b1_valid_reg;
    ssc_pkg::work_t     b1_reg;
    logic signed [31:0] h;
    logic signed [65:0] b2_prod_next;

    logic               b2_valid_reg;
    ssc_pkg::work_t     b2_reg;
    logic signed [65:0] b2_prod_reg;
    logic [31:0]        b2_h_reg;
    logic signed [66:0] s_sum, s_shift;
    logic [31:0]        b3_hv_next;
    logic               b3_sat_next;

    logic               b3_valid_reg;
    ssc_pkg::carry_t    b3_info_reg;
    logic [31:0]        b3_hv_reg;
    logic               b3_sat_reg;
    logic signed [47:0] b4_yprod_next;

    logic               b4_valid_reg;
    ssc_pkg::carry_t    b4_info_reg;
    logic [31:0]        b4_hv_reg;
    logic               b4_sat_reg;
    logic signed [47:0] b4_yprod_reg;
    logic signed [47:0] y_shift;
    logic [31:0]        y_sat;
    logic               y_flag;

    assign adv        = !(b4_valid_reg && out_full);
    assign head_reads = (q_head.info.op == ssc_pkg::OP_SCAN)
                     || (q_head.info.op == ssc_pkg::OP_READ);
    assign b1_writes  = b1_valid_reg && ((b1_reg.info.op == ssc_pkg::OP_SCAN)
                     || (b1_reg.info.op == ssc_pkg::OP_LOAD));
    assign b2_writes  = b2_valid_reg && ((b2_reg.info.op == ssc_pkg::OP_SCAN)
                     || (b2_reg.info.op == ssc_pkg::OP_LOAD));
    // wait while an earlier item still owes this entry its new value
    assign hazard     = head_reads && ((b1_writes && b1_reg.addr == q_head.addr)
                     || (b2_writes && b2_reg.addr == q_head.addr));
    assign issue      = !q_empty && adv && !hazard && !clr_busy_reg;
    assign q_pop      = issue;
    assign mem_we     = adv && b2_writes;

    // stage 1: state times decay factor
    assign h            = $signed(rd_reg);
    assign b2_prod_next = $signed({1'b0, b1_reg.abar}) * h;

    // stage 2: add input term, round, saturate for scan; load takes the init value, read keeps the state
    always_comb
    begin
        s_sum   = 67'(b2_prod_reg) + (67'($signed(b2_reg.bdx)) <<< 6);
        s_shift = (s_sum + (67'sd1 <<< 25)) >>> 26;
        b3_sat_next = 1'b0;
        unique case (b2_reg.info.op)
            ssc_pkg::OP_SCAN:
            begin
                if (s_shift > 67'sd2147483647)
                begin
                    b3_hv_next  = 32'h7fffffff;
                    b3_sat_next = 1'b1;
                end
                else if (s_shift < -67'sd2147483648)
                begin
                    b3_hv_next  = 32'h80000000;
                    b3_sat_next = 1'b1;
                end
                else
                begin
                    b3_hv_next = s_shift[31:0];
                end
            end
            ssc_pkg::OP_LOAD: b3_hv_next = b2_reg.info.init;
            ssc_pkg::OP_READ: b3_hv_next = b2_h_reg;
            ssc_pkg::OP_NONE: b3_hv_next = '0;
        endcase
    end

    // stage 3: output product
    assign b4_yprod_next = $signed(b3_info_reg.c) * $signed(b3_hv_reg);

    // stage 4: round and saturate the output; zero for all but scan
    always_comb
    begin
        y_shift = (b4_yprod_reg + 48'sd2048) >>> 12;
        y_flag  = 1'b0;
        if (y_shift > 48'sd2147483647)
        begin
            y_sat  = 32'h7fffffff;
            y_flag = 1'b1;
        end
        else if (y_shift < -48'sd2147483648)
        begin
            y_sat  = 32'h80000000;
            y_flag = 1'b1;
        end
        else
        begin
            y_sat = y_shift[31:0];
        end
        if (b4_info_reg.op != ssc_pkg::OP_SCAN)
        begin
            y_sat  = '0;
            y_flag = 1'b0;
        end
    end

    assign out_push             = b4_valid_reg && !out_full;
    assign out_data.y_value     = y_sat;
    assign out_data.state_value = b4_hv_reg;
    assign out_data.saturated   = b4_sat_reg || y_flag;
    assign out_data.index_error = b4_info_reg.ierr;
    assign out_data.last_out    = b4_info_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b4_valid_reg <= 1'b0;
        end
        else
        begin
            // clearing pass over the state memory
            if (clr_busy_reg)
            begin
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (adv)
            begin
                b1_valid_reg <= issue;
                b2_valid_reg <= b1_valid_reg;
                b3_valid_reg <= b2_valid_reg;
                b4_valid_reg <= b3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (mem_we)
        begin
            mem[b2_reg.addr[AW-1:0]] <= b3_hv_next;
        end
        if (issue)
        begin
            rd_reg <= mem[q_head.addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_reg       <= q_head;
            b2_reg       <= b1_reg;
            b2_prod_reg  <= b2_prod_next;
            b2_h_reg     <= h;
            b3_info_reg  <= b2_reg.info;
            b3_hv_reg    <= b3_hv_next;
            b3_sat_reg   <= b3_sat_next;
            b4_info_reg  <= b3_info_reg;
            b4_hv_reg    <= b3_hv_reg;
            b4_sat_reg   <= b3_sat_reg;
            b4_yprod_reg <= b4_yprod_next;
        end
    end

endmodule
